### rtl/assert_macros.svh
// Assertion macros for the rank tracker RTL.
// Each macro expects i_clk and i_rst_n in the scope of the user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MTFR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MTFR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/mtfr_pkg.sv
// Shared types and constants of the move-to-front rank tracker.
// Used by mtfr_cell and move_to_front_rank_tracker; depends on nothing.
package mtfr_pkg;

    localparam int SYM_W           = 6;
    localparam int OUT_W           = 16;
    localparam int DEF_NUM_SYMBOLS = 64;
    localparam int DEF_POS_WIDTH   = 16;

    // Lookup token walking down the row of cells.
    typedef struct packed {
        logic             valid;
        logic             found;
        logic [SYM_W-1:0] sym;
    } t_tok;

    // State change applied to all cells in the same cycle.
    typedef struct packed {
        logic             app_en;
        logic             qry_en;
        logic [SYM_W-1:0] sym;
    } t_upd;

endpackage

### rtl/mtfr_cell.sv
// One symbol cell: holds the symbol's position and present mark and one
// stage of the lookup token chain. Depends on mtfr_pkg.
module mtfr_cell import mtfr_pkg::*; #(
    parameter int IDX       = 0,
    parameter int POS_WIDTH = DEF_POS_WIDTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_tok                 i_tok,
    input  logic [POS_WIDTH-1:0] i_tok_pos,
    output t_tok                 o_tok,
    output logic [POS_WIDTH-1:0] o_tok_pos,
    input  t_upd                 i_upd,
    input  logic [POS_WIDTH-1:0] i_upd_pos
);

    logic [POS_WIDTH-1:0] r_pos;
    logic [POS_WIDTH-1:0] n_pos;
    logic                 r_present;
    logic                 n_present;
    t_tok                 r_tok;
    t_tok                 n_tok;
    logic [POS_WIDTH-1:0] r_tok_pos;
    logic [POS_WIDTH-1:0] n_tok_pos;
    logic                 w_tok_hit;
    logic                 w_upd_hit;

    assign w_tok_hit = (32'(i_tok.sym) == 32'(IDX));
    assign w_upd_hit = (32'(i_upd.sym) == 32'(IDX));

    always_comb begin
        n_tok     = i_tok;
        n_tok_pos = i_tok_pos;
        if (i_tok.valid && w_tok_hit) begin
            n_tok.found = r_present;
            n_tok_pos   = r_pos;
        end
    end

    always_comb begin
        n_pos     = r_pos;
        n_present = r_present;
        if (i_upd.app_en && w_upd_hit && !r_present) begin
            n_present = 1'b1;
            n_pos     = i_upd_pos;
        end
        if (i_upd.qry_en) begin
            if (w_upd_hit) begin
                n_pos = POS_WIDTH'(1);
            end else if (r_present && (r_pos < i_upd_pos)) begin
                n_pos = r_pos + POS_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= 1'b0;
            r_tok     <= '0;
        end else begin
            r_present <= n_present;
            r_tok     <= n_tok;
        end
        r_pos     <= n_pos;
        r_tok_pos <= n_tok_pos;
    end

    assign o_tok     = r_tok;
    assign o_tok_pos = r_tok_pos;

endmodule

### rtl/move_to_front_rank_tracker.sv
// Move-to-front rank tracker: top level with control and the row of cells.
// Depends on mtfr_pkg, mtfr_cell and assert_macros.svh.
//
// Input channel: i_valid, o_stall, fields i_action and i_symbol. An item is
// taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall, field o_position; one item per query.
// An append is applied at its accept edge (ignored if i_symbol >= NUM_SYMBOLS);
// it gives no output item.
// A query sends a lookup token down the row of NUM_SYMBOLS cells, one cell
// per cycle; the row length sets the timing. When the token leaves the row,
// the control enters S_DONE, then loads the output register, raises o_valid
// and returns to S_IDLE, where the next item is taken; o_stall is high meanwhile.
// While the receiver holds i_stall, the result stays in the output register;
// a later query waits for it at the end of its lookup before moving.
// Reset (synchronous, i_rst_n low) empties the list and clears the count.
`include "assert_macros.svh"

module move_to_front_rank_tracker import mtfr_pkg::*; #(
    parameter int NUM_SYMBOLS = DEF_NUM_SYMBOLS,
    parameter int POS_WIDTH   = DEF_POS_WIDTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic             i_action,
    input  logic [SYM_W-1:0] i_symbol,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [OUT_W-1:0] o_position
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_SWEEP = 3'b010,
        S_DONE  = 3'b100
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [POS_WIDTH-1:0] r_count;
    logic [POS_WIDTH-1:0] n_count;
    logic [POS_WIDTH-1:0] r_here;
    logic                 r_found;
    logic [SYM_W-1:0]     r_sym;
    logic                 r_out_valid;
    logic [POS_WIDTH-1:0] r_out_pos;

    logic                 w_in_acc;
    logic                 w_out_acc;
    logic                 w_app;
    logic                 w_done_go;
    t_upd                 w_upd;
    logic [POS_WIDTH-1:0] w_upd_pos;

    t_tok                 w_tok     [NUM_SYMBOLS+1];
    logic [POS_WIDTH-1:0] w_tok_pos [NUM_SYMBOLS+1];
    logic [NUM_SYMBOLS-1:0] w_tok_vld;

    assign o_stall   = (r_state != S_IDLE);
    assign w_in_acc  = i_valid && !o_stall;
    assign w_out_acc = r_out_valid && !i_stall;
    assign w_app     = w_in_acc && !i_action && (32'(i_symbol) < 32'(NUM_SYMBOLS));
    assign w_done_go = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    always_comb begin
        n_count = r_count;
        if (w_app && (r_count != {POS_WIDTH{1'b1}})) begin
            n_count = r_count + POS_WIDTH'(1);
        end
    end

    assign w_upd.app_en = w_app;
    assign w_upd.qry_en = w_done_go && r_found;
    assign w_upd.sym    = w_app ? i_symbol : r_sym;
    assign w_upd_pos    = w_app ? n_count : r_here;

    assign w_tok[0].valid = w_in_acc && i_action;
    assign w_tok[0].found = 1'b0;
    assign w_tok[0].sym   = i_symbol;
    assign w_tok_pos[0]   = '0;

    for (genvar k = 0; k < NUM_SYMBOLS; k++) begin : g_cell
        mtfr_cell #(
            .IDX       (k),
            .POS_WIDTH (POS_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_tok     (w_tok[k]),
            .i_tok_pos (w_tok_pos[k]),
            .o_tok     (w_tok[k+1]),
            .o_tok_pos (w_tok_pos[k+1]),
            .i_upd     (w_upd),
            .i_upd_pos (w_upd_pos)
        );
        assign w_tok_vld[k] = w_tok[k+1].valid;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc && i_action) begin
                    n_state = S_SWEEP;
                end
            end
            S_SWEEP: begin
                if (w_tok[NUM_SYMBOLS].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_done_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_done_go) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == S_SWEEP) && w_tok[NUM_SYMBOLS].valid) begin
                r_found <= w_tok[NUM_SYMBOLS].found;
            end
        end
        if ((r_state == S_SWEEP) && w_tok[NUM_SYMBOLS].valid) begin
            r_here <= w_tok_pos[NUM_SYMBOLS];
            r_sym  <= w_tok[NUM_SYMBOLS].sym;
        end
        if (w_done_go) begin
            r_out_pos <= r_found ? r_here : '0;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_position = OUT_W'(r_out_pos);

    `MTFR_ASSERT_IMP(a_one_token, 1'b1, $onehot0(w_tok_vld), "more than one lookup token in flight")
    `MTFR_ASSERT_IMP(a_tok_end_in_sweep, w_tok[NUM_SYMBOLS].valid, r_state == S_SWEEP, "token left chain outside lookup")
    `MTFR_ASSERT_NXT(a_query_starts, w_in_acc && i_action, r_state == S_SWEEP, "query did not start lookup")

endmodule

### tb/move_to_front_rank_tracker_tb.sv
// Self-checking testbench for move_to_front_rank_tracker: drives append and
// query items, predicts each query position in a scoreboard class.
// Depends on mtfr_pkg and the RTL of the tracker.
module move_to_front_rank_tracker_tb import mtfr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SYM = DEF_NUM_SYMBOLS;
    localparam int POS_W = DEF_POS_WIDTH;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic ACT_APPEND = 1'b0;
    localparam logic ACT_QUERY = 1'b1;
    localparam int LATENCY = NUM_SYM + 2;
    localparam int MAX_REPORTS = 10;
    localparam int RESERVED_LO = 60;

    class mtf_rank_book;
        logic [POS_W-1:0] rank [NUM_SYM];
        bit present [NUM_SYM];
        logic [POS_W-1:0] appended;
        logic [OUT_W-1:0] pending_positions [$];
        int mismatches;

        function new();
            for (int k = 0; k < NUM_SYM; k++) begin
                rank[k] = '0;
                present[k] = 1'b0;
            end
            appended = '0;
            mismatches = 0;
        endfunction

        function void note_item(logic act, logic [SYM_W-1:0] sym);
            logic [POS_W-1:0] here;
            if (act == ACT_APPEND) begin
                if (int'(sym) < NUM_SYM) begin
                    if (appended != POS_MAX) appended = appended + 1'b1;
                    if (!present[sym]) begin
                        present[sym] = 1'b1;
                        rank[sym] = appended;
                    end
                end
            end else if (int'(sym) >= NUM_SYM || !present[sym]) begin
                pending_positions.insert(pending_positions.size(), OUT_W'(0));
            end else begin
                here = rank[sym];
                pending_positions.insert(pending_positions.size(), OUT_W'(here));
                for (int k = 0; k < NUM_SYM; k++) begin
                    if (present[k] && rank[k] < here) rank[k] = rank[k] + 1'b1;
                end
                rank[sym] = POS_W'(1);
            end
        endfunction

        function void check_position(logic [OUT_W-1:0] got);
            logic [OUT_W-1:0] want;
            if (pending_positions.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected item: position %0d", got);
            end else begin
                want = pending_positions.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("position mismatch: expected %0d, actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_action = ACT_APPEND;
    logic [SYM_W-1:0] i_symbol = '0;
    logic i_stall = 1'b0;
    logic o_stall;
    logic o_valid;
    logic [OUT_W-1:0] o_position;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_len = 0;
    int hold_left = 0;
    mtf_rank_book book = new();

    move_to_front_rank_tracker #(
        .NUM_SYMBOLS(NUM_SYM),
        .POS_WIDTH  (POS_W)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_action  (i_action),
        .i_symbol  (i_symbol),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_position(o_position)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) book.check_position(o_position);
        if (hold_len > 0) begin
            hold_left = hold_len;
            hold_len = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    task automatic send_item(input logic act, input int sym);
        while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_symbol <= SYM_W'(sym);
        do @(posedge i_clk); while (o_stall);
        book.note_item(act, SYM_W'(sym));
    endtask

    // keep the reserved symbols absent until the final directed items
    task automatic send_random(input int count);
        logic act;
        int sym;
        for (int n = 0; n < count; n++) begin
            act = ($urandom_range(99) < 45) ? ACT_APPEND : ACT_QUERY;
            if (act == ACT_APPEND || $urandom_range(9) != 0)
                sym = int'($urandom_range(RESERVED_LO - 1));
            else
                sym = int'($urandom_range(NUM_SYM - 1, RESERVED_LO));
            send_item(act, sym);
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (book.pending_positions.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        tx_idle_pct = 15;
        rx_idle_pct = 59;
        send_item(ACT_QUERY, 0);
        send_item(ACT_APPEND, 0);
        send_item(ACT_APPEND, 0);
        send_item(ACT_APPEND, 59);
        send_item(ACT_APPEND, 21);
        send_item(ACT_APPEND, 42);
        send_item(ACT_QUERY, 42);
        send_item(ACT_QUERY, 42);
        send_item(ACT_QUERY, 0);
        send_item(ACT_QUERY, 21);
        send_item(ACT_QUERY, 63);
        send_item(ACT_APPEND, 32);
        send_item(ACT_APPEND, 31);
        send_item(ACT_QUERY, 59);
        send_item(ACT_QUERY, 31);
        send_item(ACT_QUERY, 31);
        send_item(ACT_QUERY, 5);
        send_item(ACT_QUERY, 32);
        drain();

        send_random(200);
        hold_len = 400;
        send_random(450);
        drain();

        tx_idle_pct = 59;
        rx_idle_pct = 15;
        send_random(650);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(650);
        send_item(ACT_APPEND, 7);
        send_item(ACT_APPEND, 60);
        send_item(ACT_APPEND, 61);
        send_item(ACT_QUERY, 60);
        send_item(ACT_QUERY, 61);
        send_item(ACT_QUERY, 62);
        send_item(ACT_APPEND, 62);
        send_item(ACT_QUERY, 63);
        send_item(ACT_APPEND, 63);
        send_item(ACT_QUERY, 62);
        send_item(ACT_QUERY, 63);
        send_random(40);
        drain();
        repeat (LATENCY + 8) @(posedge i_clk);

        if (book.mismatches == 0 && book.pending_positions.size() == 0) begin
            $display("[move_to_front_rank_tracker] OK");
        end else begin
            $display("[move_to_front_rank_tracker] ERROR");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[move_to_front_rank_tracker] ERROR");
        $finish;
    end

endmodule
